>>> hdl/rrc_pkg.sv
package rrc_pkg;

	localparam int IDX_W = 13;
	localparam int CNT_W = 14;

	localparam logic [1:0] OUT_EXACT = 2'd0;
	localparam logic [1:0] OUT_RANGE = 2'd1;
	localparam logic [1:0] OUT_NEW   = 2'd2;
	localparam logic [1:0] OUT_FAIL  = 2'd3;

	typedef struct packed {
		logic [63:0] address;
		logic [47:0] length;
		logic        alloc_known;
		logic [63:0] alloc_start;
		logic [47:0] alloc_length;
		logic        register_ok;
	} req_t;

	typedef struct packed {
		logic        covered;
		logic [1:0]  outcome;
		logic [6:0]  removed_count;
		logic        lru_evicted;
		logic [63:0] extent_base;
		logic [47:0] extent_length;
	} rsp_t;

	typedef enum logic [1:0] {
		MODE_LOOK,
		MODE_CLEAR,
		MODE_SCAN
	} mode_t;

	// pass command seen by every cell
	typedef struct packed {
		mode_t       mode;
		logic [63:0] key;
		logic [47:0] klen;
	} qry_t;

	// accumulator that walks the chain with the token
	typedef struct packed {
		logic             tok;
		logic             f_hit;
		logic [IDX_W-1:0] f_idx;
		logic [47:0]      f_len;
		logic             p_hit;
		logic [IDX_W-1:0] p_idx;
		logic [63:0]      p_base;
		logic [47:0]      p_len;
		logic [63:0]      p_tick;
		logic             z_hit;
		logic [IDX_W-1:0] z_idx;
		logic [CNT_W-1:0] cnt;
	} acc_t;

	typedef struct packed {
		logic             inv_en;
		logic [IDX_W-1:0] inv_idx;
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic [63:0]      base;
		logic [47:0]      len;
		logic [63:0]      tick;
	} cmd_t;

	function automatic logic span_inside(logic [63:0] b, logic [47:0] len,
		logic [63:0] p, logic [47:0] n);
		logic [63:0] off;
		logic [63:0] room;
		off  = p - b;
		room = {16'd0, len} - off;
		return (p >= b) && (off <= {16'd0, len}) && ({16'd0, n} <= room);
	endfunction

endpackage

>>> hdl/rrc_cell.sv
module rrc_cell #(
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rrc_pkg::qry_t qry,
	input  rrc_pkg::cmd_t cmd,
	input  rrc_pkg::acc_t acc_in,
	output rrc_pkg::acc_t acc_out
);

	logic        valid_q;
	logic [63:0] base_q;
	logic [47:0] len_q;
	logic [63:0] tick_q;
	rrc_pkg::acc_t nxt;
	logic        rm;
	logic        wr_me;
	logic        inv_me;
	logic [63:0] diff;
	localparam logic [rrc_pkg::IDX_W-1:0] MY_IDX = rrc_pkg::IDX_W'(IDX);

	assign wr_me  = cmd.wr_en && (cmd.wr_idx == MY_IDX);
	assign inv_me = cmd.inv_en && (cmd.inv_idx == MY_IDX);
	assign diff   = base_q - qry.key;

	always_comb begin
		nxt = acc_in;
		rm  = 1'b0;
		if (acc_in.tok) begin
			unique case (qry.mode)
				rrc_pkg::MODE_LOOK: begin
					if (valid_q && base_q == qry.key) begin
						nxt.f_hit = 1'b1;
						nxt.f_idx = MY_IDX;
						nxt.f_len = len_q;
					end
					if (valid_q && base_q <= qry.key &&
						(!acc_in.p_hit || base_q > acc_in.p_base)) begin
						nxt.p_hit  = 1'b1;
						nxt.p_idx  = MY_IDX;
						nxt.p_base = base_q;
						nxt.p_len  = len_q;
					end
				end
				rrc_pkg::MODE_CLEAR: begin
					if (valid_q && base_q < qry.key &&
						(!acc_in.p_hit || base_q > acc_in.p_base)) begin
						nxt.p_hit  = 1'b1;
						nxt.p_idx  = MY_IDX;
						nxt.p_base = base_q;
						nxt.p_len  = len_q;
					end
					if (valid_q && base_q >= qry.key && diff < {16'd0, qry.klen}) begin
						rm      = 1'b1;
						nxt.cnt = acc_in.cnt + rrc_pkg::CNT_W'(1);
					end
				end
				rrc_pkg::MODE_SCAN: begin
					if (valid_q) begin
						nxt.cnt = acc_in.cnt + rrc_pkg::CNT_W'(1);
						if (base_q == qry.key && !acc_in.f_hit) begin
							nxt.f_hit = 1'b1;
							nxt.f_idx = MY_IDX;
						end
						if (!acc_in.p_hit || tick_q < acc_in.p_tick ||
							(tick_q == acc_in.p_tick && base_q < acc_in.p_base)) begin
							nxt.p_hit  = 1'b1;
							nxt.p_idx  = MY_IDX;
							nxt.p_base = base_q;
							nxt.p_tick = tick_q;
						end
					end else if (!acc_in.z_hit) begin
						nxt.z_hit = 1'b1;
						nxt.z_idx = MY_IDX;
					end
				end
				default: begin
					nxt = acc_in;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			acc_out <= '0;
		end else begin
			acc_out <= nxt;
			if (wr_me) begin
				valid_q <= 1'b1;
			end else if (inv_me || rm) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_me) begin
			base_q <= cmd.base;
			len_q  <= cmd.len;
			tick_q <= cmd.tick;
		end
	end

endmodule

>>> hdl/range_registration_cache_lru.sv
// Range registration cache with least-recently-used replacement.
// Request channel: req_valid / req_stall / req. A request is taken when
// req_valid is high and req_stall low; req_stall is high while a request
// is being worked on.
// Response channel: rsp_valid / rsp_stall / rsp, one response per request.
// A finished response sits in an output register; the next request can be
// taken while it waits.
// Each entry lives in one cell of a chain; a token carrying the running
// search result moves one cell per cycle. A hit needs one pass over the
// chain, a miss needs three (lookup, overlap removal, LRU/slot scan), so
// the time a request takes is set by the chain length. The result is
// registered at the end of the last pass and moves to the output register
// in ST_DONE, which then turns the response valid.
// Reset empties the table and the use clock at once; no clearing pass.
// While rsp_stall is high the output register holds; a further request
// still runs to completion and then waits with req_stall high until the
// held response is transferred.
module range_registration_cache_lru #(
	parameter int ENTRIES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rrc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rrc_pkg::rsp_t rsp
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LOOK  = 5'b00010,
		ST_CLEAR = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	logic   start_q;
	rrc_pkg::qry_t qry_q;
	rrc_pkg::req_t req_q;
	rrc_pkg::cmd_t cmd;
	rrc_pkg::acc_t chain [ENTRIES+1];
	rrc_pkg::acc_t fin;
	rrc_pkg::rsp_t res_q;
	rrc_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;
	logic [63:0]   use_clock_q;
	logic [63:0]   rb_q;
	logic [47:0]   rl_q;
	logic [rrc_pkg::CNT_W-1:0] rem_q;
	logic [ENTRIES:0] tokv;

	logic          exact_hit;
	logic          range_hit;
	logic          snap;
	logic [63:0]   tgt_base;
	logic [47:0]   tgt_len;
	logic          prev_ov;
	logic          evict;
	logic          slot_ok;
	logic [rrc_pkg::IDX_W-1:0] slot_idx;
	logic [63:0]   tick_nxt;
	logic [rrc_pkg::CNT_W-1:0] rem_tot;

	always_comb begin
		chain[0]     = '0;
		chain[0].tok = start_q;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		rrc_cell #(.IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.qry    (qry_q),
			.cmd    (cmd),
			.acc_in (chain[i]),
			.acc_out(chain[i+1])
		);
	end

	for (genvar i = 0; i <= ENTRIES; i++) begin : g_tok
		assign tokv[i] = chain[i].tok;
	end

	assign fin       = chain[ENTRIES];
	assign tick_nxt  = use_clock_q + 64'd1;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign exact_hit = fin.f_hit && (fin.f_len == req_q.length);
	assign range_hit = !fin.f_hit && fin.p_hit &&
		rrc_pkg::span_inside(fin.p_base, fin.p_len, req_q.address, req_q.length);
	assign snap = req_q.alloc_known && (req_q.alloc_length != 48'd0) &&
		rrc_pkg::span_inside(req_q.alloc_start, req_q.alloc_length,
			req_q.address, req_q.length);
	assign tgt_base = snap ? req_q.alloc_start : req_q.address;
	assign tgt_len  = snap ? req_q.alloc_length : req_q.length;
	assign prev_ov  = fin.p_hit && ((rb_q - fin.p_base) < {16'd0, fin.p_len});
	assign rem_tot  = rem_q + fin.cnt + rrc_pkg::CNT_W'(prev_ov);
	assign evict    = (fin.cnt == rrc_pkg::CNT_W'(ENTRIES));

	// existing base first, then a free cell, then the evicted one
	always_comb begin
		slot_ok  = 1'b1;
		slot_idx = fin.f_idx;
		priority if (fin.f_hit) begin
			slot_idx = fin.f_idx;
		end else if (fin.z_hit) begin
			slot_idx = fin.z_idx;
		end else if (evict) begin
			slot_idx = fin.p_idx;
		end else begin
			slot_ok = 1'b0;
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.tick = tick_nxt;
		if (fin.tok) begin
			unique case (state_q)
				ST_LOOK: begin
					if (exact_hit) begin
						cmd.wr_en  = 1'b1;
						cmd.wr_idx = fin.f_idx;
						cmd.base   = req_q.address;
						cmd.len    = req_q.length;
					end else if (range_hit) begin
						cmd.wr_en  = 1'b1;
						cmd.wr_idx = fin.p_idx;
						cmd.base   = fin.p_base;
						cmd.len    = fin.p_len;
					end else begin
						cmd.inv_en  = fin.f_hit;
						cmd.inv_idx = fin.f_idx;
					end
				end
				ST_CLEAR: begin
					cmd.inv_en  = prev_ov;
					cmd.inv_idx = fin.p_idx;
				end
				ST_SCAN: begin
					cmd.inv_en  = evict;
					cmd.inv_idx = fin.p_idx;
					cmd.wr_en   = req_q.register_ok && slot_ok;
					cmd.wr_idx  = slot_idx;
					cmd.base    = rb_q;
					cmd.len     = rl_q;
				end
				default: begin
					cmd.wr_en = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			use_clock_q <= 64'd0;
		end else begin
			// launch a token on acceptance and between the passes of a miss
			start_q <= (state_q == ST_IDLE && req_valid) ||
				(fin.tok && (state_q == ST_CLEAR ||
				(state_q == ST_LOOK && !exact_hit && !range_hit)));
			if (state_q == ST_DONE && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cmd.wr_en) begin
				use_clock_q <= tick_nxt;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (fin.tok) begin
						if (exact_hit || range_hit) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_CLEAR;
						end
					end
				end
				ST_CLEAR: begin
					if (fin.tok) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (fin.tok) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				req_q     <= req;
				qry_q     <= '{mode: rrc_pkg::MODE_LOOK, key: req.address, klen: req.length};
			end
			ST_LOOK: begin
				if (fin.tok) begin
					res_q.covered       <= 1'b1;
					res_q.outcome       <= exact_hit ? rrc_pkg::OUT_EXACT : rrc_pkg::OUT_RANGE;
					res_q.removed_count <= 7'd0;
					res_q.lru_evicted   <= 1'b0;
					res_q.extent_base   <= exact_hit ? req_q.address : fin.p_base;
					res_q.extent_length <= exact_hit ? req_q.length : fin.p_len;
					rem_q <= rrc_pkg::CNT_W'(fin.f_hit);
					rb_q  <= tgt_base;
					rl_q  <= tgt_len;
					qry_q <= '{mode: rrc_pkg::MODE_CLEAR, key: tgt_base, klen: tgt_len};
				end
			end
			ST_CLEAR: begin
				if (fin.tok) begin
					rem_q <= rem_tot;
					qry_q <= '{mode: rrc_pkg::MODE_SCAN, key: rb_q, klen: rl_q};
				end
			end
			ST_SCAN: begin
				if (fin.tok) begin
					res_q.covered       <= cmd.wr_en;
					res_q.outcome       <= cmd.wr_en ? rrc_pkg::OUT_NEW : rrc_pkg::OUT_FAIL;
					res_q.removed_count <= (rem_q > rrc_pkg::CNT_W'(127)) ? 7'd127 : rem_q[6:0];
					res_q.lru_evicted   <= evict;
					res_q.extent_base   <= rb_q;
					res_q.extent_length <= rl_q;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_q <= res_q;
				end
			end
			default: begin
				rsp_q <= rsp_q;
			end
		endcase
	end

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tokv))
		else $error("more than one token in the chain");

	a_idle_no_token: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !fin.tok)
		else $error("token left the chain while idle");

	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.outcome == rrc_pkg::OUT_EXACT || rsp.outcome == rrc_pkg::OUT_RANGE)
		|-> rsp.removed_count == 7'd0 && !rsp.lru_evicted)
		else $error("hit reported removals");

	a_covered: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.covered == (rsp.outcome != rrc_pkg::OUT_FAIL))
		else $error("covered disagrees with outcome");

endmodule
